// ----- rtl/pah_pkg.sv -----
// Shared types and constants for the periodic autocorrelation block.
// No dependencies; used by pah_ctrl, pah_dp and the top level.
package pah_pkg;

    localparam int SAMPLE_W   = 6;
    localparam int CFG_W      = 6;
    localparam int SHIFT_W    = 5;
    localparam int CORR_W     = 12;
    localparam int CORR_LIMIT = 1024;

    localparam logic [CFG_W-1:0] CFG_LEN_RESET = CFG_W'(32);

    // Command from the sequencer to the datapath for one multiply-accumulate term.
    typedef struct packed {
        logic               rd;       // a term is issued this cycle
        logic               first;    // first term of a shift: restart the sum
        logic               last;     // last term of a shift: produce a result
        logic               final_sh; // this shift is the last of the sequence
        logic [SHIFT_W-1:0] shift;
    } t_cmd;

endpackage

// ----- rtl/periodic_autocorrelation_half_top.sv -----
// After loading, one result is produced per shift from zero to len/2, each a sum of len
// terms. Throughput: one sample a cycle while loading; no samples are taken during
// computation, which is bound by the single shared multiply-accumulate unit (one term per
// cycle while no result is held back).
// Reset (synchronous, active low) sets the length to 32 and the load count to zero;
// the sample memory is not cleared, and an entry is only ever read after it was written.
// Top level of the periodic autocorrelation block. Depends on pah_pkg, pah_ctrl, pah_dp.
module periodic_autocorrelation_half_top #(
    parameter int MAX_LENGTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration: sequence length, written when the block is idle.
    input  logic                                i_cfg_wr_en,
    input  logic [pah_pkg::CFG_W-1:0]           i_cfg_wr_data,
    // Sample requests.
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [pah_pkg::SAMPLE_W-1:0] i_sample,
    // Result requests.
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pah_pkg::SHIFT_W-1:0]         o_shift,
    output logic signed [pah_pkg::CORR_W-1:0]   o_corr_value,
    output logic                                o_out_of_range,
    output logic                                o_last_result
);

    localparam int AW = $clog2(MAX_LENGTH);

    // The sequencer writes samples while loading, then walks every shift s from zero to
    // len/2 and, within it, every term j, addressing x[j] and x[(j+s) mod len]. The
    // datapath accumulates one product a cycle unless stalled and clamps the finished sum.
    logic          w_advance;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr_a;
    logic [AW-1:0] w_rd_addr_b;
    pah_pkg::t_cmd w_cmd;

    pah_ctrl #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_advance     (w_advance),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_rd_addr_a   (w_rd_addr_a),
        .o_rd_addr_b   (w_rd_addr_b),
        .o_cmd         (w_cmd)
    );

    // The datapath stalls the sequencer whenever a result is held back by the receiver.
    pah_dp #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr_en        (w_wr_en),
        .i_wr_addr      (w_wr_addr),
        .i_wr_data      (i_sample),
        .i_rd_addr_a    (w_rd_addr_a),
        .i_rd_addr_b    (w_rd_addr_b),
        .i_cmd          (w_cmd),
        .o_advance      (w_advance),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_shift        (o_shift),
        .o_corr_value   (o_corr_value),
        .o_out_of_range (o_out_of_range),
        .o_last_result  (o_last_result)
    );

endmodule

// ----- rtl/pah_ctrl.sv -----
// Sequencer of the periodic autocorrelation block: length register, load
// counter and the shift and term counters. Depends on pah_pkg.
module pah_ctrl #(
    parameter int MAX_LENGTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [pah_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_advance,
    output logic                        o_wr_en,
    output logic [$clog2(MAX_LENGTH)-1:0] o_wr_addr,
    output logic [$clog2(MAX_LENGTH)-1:0] o_rd_addr_a,
    output logic [$clog2(MAX_LENGTH)-1:0] o_rd_addr_b,
    output pah_pkg::t_cmd               o_cmd
);

    localparam int AW = $clog2(MAX_LENGTH);
    localparam int LW = $clog2(MAX_LENGTH + 1);

    typedef enum logic {
        S_LOAD,
        S_RUN
    } t_state;

    t_state                     r_state;
    logic [pah_pkg::CFG_W-1:0]  r_cfg_len;
    logic [AW-1:0]              r_count;
    logic [AW-1:0]              r_j;
    logic [AW-1:0]              r_idx;
    logic [AW-1:0]              r_s;

    logic [LW-1:0] w_len;
    logic [LW-1:0] w_half;
    logic          w_accept;
    logic          w_term_last;
    logic          w_shift_last;

    always_comb begin
        if (r_cfg_len == '0) begin
            w_len = LW'(1);
        end else if (int'(r_cfg_len) > MAX_LENGTH) begin
            w_len = LW'(MAX_LENGTH);
        end else begin
            w_len = LW'(r_cfg_len);
        end
    end

    assign w_half       = w_len >> 1;
    assign o_in_ready   = (r_state == S_LOAD);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_term_last  = (LW'(r_j) + LW'(1)) == w_len;
    assign w_shift_last = LW'(r_s) == w_half;

    assign o_wr_en        = w_accept;
    assign o_wr_addr      = r_count;
    assign o_rd_addr_a    = r_j;
    assign o_rd_addr_b    = r_idx;
    assign o_cmd.rd       = (r_state == S_RUN);
    assign o_cmd.first    = (r_j == '0);
    assign o_cmd.last     = w_term_last;
    assign o_cmd.final_sh = w_shift_last;
    assign o_cmd.shift    = pah_pkg::SHIFT_W'(r_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_cfg_len <= pah_pkg::CFG_LEN_RESET;
            r_count   <= '0;
            r_j       <= '0;
            r_idx     <= '0;
            r_s       <= '0;
        end else if (i_cfg_wr_en) begin
            // A write discards any partly loaded sequence and stops a computation in progress.
            r_cfg_len <= i_cfg_wr_data;
            r_count   <= '0;
            r_state   <= S_LOAD;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (w_accept) begin
                        if ((LW'(r_count) + LW'(1)) >= w_len) begin
                            r_count <= '0;
                            r_j     <= '0;
                            r_idx   <= '0;
                            r_s     <= '0;
                            r_state <= S_RUN;
                        end else begin
                            r_count <= r_count + AW'(1);
                        end
                    end
                end
                S_RUN: begin
                    if (i_advance) begin
                        if (w_term_last) begin
                            r_j <= '0;
                            if (w_shift_last) begin
                                r_state <= S_LOAD;
                            end else begin
                                r_s   <= r_s + AW'(1);
                                r_idx <= r_s + AW'(1);
                            end
                        end else begin
                            r_j <= r_j + AW'(1);
                            if ((LW'(r_idx) + LW'(1)) == w_len) begin
                                r_idx <= '0;
                            end else begin
                                r_idx <= r_idx + AW'(1);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

endmodule

// ----- rtl/pah_dp.sv -----
// Datapath of the periodic autocorrelation block: sample memory with two
// read ports, multiply-accumulate, clamping and result register. Depends on pah_pkg.
module pah_dp #(
    parameter int MAX_LENGTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_wr_en,
    input  logic [$clog2(MAX_LENGTH)-1:0]      i_wr_addr,
    input  logic signed [pah_pkg::SAMPLE_W-1:0] i_wr_data,
    input  logic [$clog2(MAX_LENGTH)-1:0]      i_rd_addr_a,
    input  logic [$clog2(MAX_LENGTH)-1:0]      i_rd_addr_b,
    input  pah_pkg::t_cmd                      i_cmd,
    output logic                               o_advance,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [pah_pkg::SHIFT_W-1:0]        o_shift,
    output logic signed [pah_pkg::CORR_W-1:0]  o_corr_value,
    output logic                               o_out_of_range,
    output logic                               o_last_result
);

    localparam int AW    = $clog2(MAX_LENGTH);
    localparam int PW    = 2 * pah_pkg::SAMPLE_W;
    localparam int ACC_W = PW + AW + 1;
    localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(pah_pkg::CORR_LIMIT);
    localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI;

    logic signed [pah_pkg::SAMPLE_W-1:0] r_mem [MAX_LENGTH];

    logic signed [pah_pkg::SAMPLE_W-1:0] r_a;
    logic signed [pah_pkg::SAMPLE_W-1:0] r_b;
    pah_pkg::t_cmd                       r_cmd;
    logic signed [ACC_W-1:0]             r_acc;

    logic signed [PW-1:0]    w_prod;
    logic signed [ACC_W-1:0] w_sum;

    // The whole pipeline holds while a result waits and is not taken.
    assign o_advance = !(o_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (o_advance && i_cmd.rd) begin
            r_a <= r_mem[i_rd_addr_a];
            r_b <= r_mem[i_rd_addr_b];
        end
    end

    assign w_prod = r_a * r_b;
    assign w_sum  = r_cmd.first ? ACC_W'(w_prod) : r_acc + ACC_W'(w_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_cmd <= i_cmd;
            end
            if (o_advance && r_cmd.rd && r_cmd.last) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && r_cmd.rd) begin
            r_acc <= w_sum;
            if (r_cmd.last) begin
                o_shift       <= r_cmd.shift;
                o_last_result <= r_cmd.final_sh;
                if (w_sum > LIM_HI) begin
                    o_corr_value   <= pah_pkg::CORR_W'(LIM_HI);
                    o_out_of_range <= 1'b1;
                end else if (w_sum < LIM_LO) begin
                    o_corr_value   <= pah_pkg::CORR_W'(LIM_LO);
                    o_out_of_range <= 1'b1;
                end else begin
                    o_corr_value   <= w_sum[pah_pkg::CORR_W-1:0];
                    o_out_of_range <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- rtl/pah_chk.sv -----
// Port-level checks for the periodic autocorrelation block, bound to its top level.
// Depends on pah_pkg and periodic_autocorrelation_half_top.
module pah_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input logic [pah_pkg::SHIFT_W-1:0]         o_shift,
    input logic signed [pah_pkg::CORR_W-1:0]   o_corr_value,
    input logic                                o_out_of_range
);

    localparam logic signed [pah_pkg::CORR_W-1:0] LIM_HI =
        pah_pkg::CORR_W'(pah_pkg::CORR_LIMIT);
    localparam logic signed [pah_pkg::CORR_W-1:0] LIM_LO = -LIM_HI;

    // Reset leaves no result pending.
    a_reset_clears : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A held-back result keeps its content.
    a_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_corr_value) && $stable(o_shift)
            && $stable(o_out_of_range))
        else $error("result changed while held");

    // Every result lies within the clamp range.
    a_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_corr_value <= LIM_HI) && (o_corr_value >= LIM_LO))
        else $error("result outside clamp range");

    // A flagged result sits exactly on one of the limits.
    a_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_of_range |-> (o_corr_value == LIM_HI) || (o_corr_value == LIM_LO))
        else $error("out-of-range flag without clamped value");

endmodule

bind periodic_autocorrelation_half_top pah_chk u_pah_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_shift        (o_shift),
    .o_corr_value   (o_corr_value),
    .o_out_of_range (o_out_of_range)
);
